// File: rtl/core/smm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;

  localparam int FIELD_W    = 28;
  localparam int DIGIT_BITS = 28;
  localparam int MAX_DIGITS = 16;
  localparam int PROD_DEPTH = 2 * MAX_DIGITS;

  localparam int AIDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
  localparam int PIDX_W = $clog2(PROD_DEPTH);
  localparam int NCNT_W = $clog2(PROD_DEPTH + 1);
  localparam int PSUM_W = 2 * DIGIT_BITS + $clog2(MAX_DIGITS);
  localparam int ACC_W  = PSUM_W + 1;
  localparam int CARRY_W = ACC_W - DIGIT_BITS;
  localparam int RUN_W  = $clog2(PROD_DEPTH + MAX_DIGITS + 3);

  localparam logic [1:0] OP_LOAD_A   = 2'd0;
  localparam logic [1:0] OP_LOAD_B   = 2'd1;
  localparam logic [1:0] OP_MULTIPLY = 2'd2;

  typedef struct packed {
    logic              clear;
    logic              a_we;
    logic [AIDX_W-1:0] a_idx;
    logic [LEN_W-1:0]  a_len;
  } chain_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/smm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module smm_cell (
  input  wire logic                          clk,
  input  wire logic                          clear,
  input  wire logic                          a_we,
  input  wire logic                          a_active,
  input  wire logic [smm_pkg::DIGIT_BITS-1:0] a_digit,
  input  wire logic [smm_pkg::DIGIT_BITS-1:0] b_in,
  output logic      [smm_pkg::DIGIT_BITS-1:0] b_out,
  input  wire logic [smm_pkg::PSUM_W-1:0]     psum_in,
  output logic      [smm_pkg::PSUM_W-1:0]     psum_out
);
  import smm_pkg::*;

  logic [DIGIT_BITS-1:0]   a_r;
  logic [DIGIT_BITS-1:0]   b1_r;
  logic [DIGIT_BITS-1:0]   b2_r;
  logic [2*DIGIT_BITS-1:0] prod_r;
  logic [PSUM_W-1:0]       psum_r;

  // operand digit held in place
  always_ff @(posedge clk) begin
    if (a_we) begin
      a_r <= a_digit;
    end
  end

  // b moves at half speed, partial sum at full speed: skewed column sums
  always_ff @(posedge clk) begin
    if (clear) begin
      b1_r <= '0;
      b2_r <= '0;
    end else begin
      b1_r <= b_in;
      b2_r <= b1_r;
    end
    prod_r <= a_active ? (2*DIGIT_BITS)'(a_r) * (2*DIGIT_BITS)'(b_in) : '0;
    psum_r <= psum_in + PSUM_W'(prod_r);
  end

  assign b_out    = b2_r;
  assign psum_out = psum_r;

endmodule
`default_nettype wire

// File: rtl/core/smm_chain.sv
`timescale 1ns / 1ps
`default_nettype none
module smm_chain (
  input  wire logic                          clk,
  input  wire smm_pkg::chain_ctrl_t          ctrl,
  input  wire logic [smm_pkg::DIGIT_BITS-1:0] a_digit,
  input  wire logic [smm_pkg::DIGIT_BITS-1:0] b_feed,
  output logic      [smm_pkg::PSUM_W-1:0]     column_sum
);
  import smm_pkg::*;

  logic [DIGIT_BITS-1:0] b_link [MAX_DIGITS+1];
  logic [PSUM_W-1:0]     s_link [MAX_DIGITS+1];

  assign b_link[0] = b_feed;
  assign s_link[0] = '0;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    smm_cell u_cell (
      .clk      (clk),
      .clear    (ctrl.clear),
      .a_we     (ctrl.a_we && (ctrl.a_idx == AIDX_W'(i))),
      .a_active (LEN_W'(i) < ctrl.a_len),
      .a_digit  (a_digit),
      .b_in     (b_link[i]),
      .b_out    (b_link[i+1]),
      .psum_in  (s_link[i]),
      .psum_out (s_link[i+1])
    );
  end

  assign column_sum = s_link[MAX_DIGITS];

endmodule
`default_nettype wire

// File: rtl/core/signed_multiprecision_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | valid      | stall      | payload
// ---------+------------+------------+------------------------------------------------
// input    | in_valid   | in_stall   | in_op, in_digit, in_a_negative, in_b_negative
// output   | out_valid  | out_stall  | out_product_digit, out_last_digit, out_negative,
//          |            |            | out_operand_overflow
//
// load words are taken while in_stall is low; op code 3 is taken and ignored
// a multiply word runs through the cell row (one column leaves the row per
// cycle after the pipeline fills), then emits one product word per cycle
// that the output side does not stall
// in_stall is high from a multiply until its last product word is registered
// synchronous active-low reset clears lengths, flags, state and output valid
module signed_multiprecision_multiply (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_op,
  input  wire logic [smm_pkg::FIELD_W-1:0] in_digit,
  input  wire logic                       in_a_negative,
  input  wire logic                       in_b_negative,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [smm_pkg::FIELD_W-1:0] out_product_digit,
  output logic                            out_last_digit,
  output logic                            out_negative,
  output logic                            out_operand_overflow
);
  import smm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam int CAP_OFF = MAX_DIGITS + 2;

  logic [1:0]           state_r, state_nxt;
  logic [LEN_W-1:0]     a_len_r, b_len_r;
  logic                 ovf_seen_r;
  logic                 neg_sign_r, ovf_word_r;
  logic [RUN_W-1:0]     run_r;
  logic [CARRY_W-1:0]   carry_r;
  logic [NCNT_W-1:0]    nlast_r;
  logic [PIDX_W-1:0]    emit_r;
  logic [DIGIT_BITS-1:0] feed_r;
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_digit_r;
  logic                 out_last_r, out_neg_r, out_ovf_r;

  logic [DIGIT_BITS-1:0] b_mem [MAX_DIGITS];
  logic [DIGIT_BITS-1:0] p_mem [PROD_DEPTH];

  logic                 accept, load_a, load_b, start;
  logic [LEN_W:0]       cols;
  logic [RUN_W-1:0]     col_off;
  logic                 capture, run_end;
  logic [PSUM_W-1:0]    column_sum;
  logic [ACC_W-1:0]     acc;
  logic                 zero_prod, out_free, emit_last;
  chain_ctrl_t          ctrl;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_a   = accept && (in_op == OP_LOAD_A);
  assign load_b   = accept && (in_op == OP_LOAD_B);
  assign start    = accept && (in_op == OP_MULTIPLY);

  // column timing through the row
  assign cols    = {1'b0, a_len_r} + {1'b0, b_len_r};
  assign col_off = run_r - RUN_W'(CAP_OFF);
  assign capture = (state_r == ST_RUN) && (run_r >= RUN_W'(CAP_OFF))
                   && (col_off < RUN_W'(cols));
  assign run_end = (run_r == RUN_W'(cols) + RUN_W'(MAX_DIGITS + 1));
  assign acc     = ACC_W'(column_sum) + ACC_W'(carry_r);

  assign zero_prod = (nlast_r == '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = zero_prod || (NCNT_W'(emit_r) + NCNT_W'(1) == nlast_r);

  always_comb begin
    ctrl.clear = start;
    ctrl.a_we  = load_a && (a_len_r < LEN_W'(MAX_DIGITS));
    ctrl.a_idx = a_len_r[AIDX_W-1:0];
    ctrl.a_len = a_len_r;
  end

  smm_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .a_digit    (in_digit[DIGIT_BITS-1:0]),
    .b_feed     (feed_r),
    .column_sum (column_sum)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (run_end) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free && emit_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // operand b store
  always_ff @(posedge clk) begin
    if (load_b && (b_len_r < LEN_W'(MAX_DIGITS))) begin
      b_mem[b_len_r[AIDX_W-1:0]] <= in_digit[DIGIT_BITS-1:0];
    end
  end

  // feed of the row: one b digit per column, zeros after
  always_ff @(posedge clk) begin
    if (start) begin
      feed_r <= '0;
    end else if ((state_r == ST_RUN) && (run_r < RUN_W'(b_len_r))) begin
      feed_r <= b_mem[run_r[AIDX_W-1:0]];
    end else begin
      feed_r <= '0;
    end
  end

  // product store
  always_ff @(posedge clk) begin
    if (capture) begin
      p_mem[col_off[PIDX_W-1:0]] <= acc[DIGIT_BITS-1:0];
    end
  end

  // output word register, doubles as product store read
  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_digit_r <= zero_prod ? '0 : FIELD_W'(p_mem[emit_r]);
      out_last_r  <= emit_last;
      out_neg_r   <= neg_sign_r && !zero_prod;
      out_ovf_r   <= ovf_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_sign_r <= in_a_negative ^ in_b_negative;
      ovf_word_r <= ovf_seen_r;
    end
    if (start) begin
      carry_r <= '0;
    end else if (capture) begin
      carry_r <= acc[ACC_W-1:DIGIT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_len_r     <= '0;
      b_len_r     <= '0;
      ovf_seen_r  <= 1'b0;
      run_r       <= '0;
      nlast_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_a) begin
        if (a_len_r < LEN_W'(MAX_DIGITS)) a_len_r <= a_len_r + LEN_W'(1);
        else ovf_seen_r <= 1'b1;
      end
      if (load_b) begin
        if (b_len_r < LEN_W'(MAX_DIGITS)) b_len_r <= b_len_r + LEN_W'(1);
        else ovf_seen_r <= 1'b1;
      end
      if (start) begin
        ovf_seen_r <= 1'b0;
        run_r      <= '0;
        nlast_r    <= '0;
        emit_r     <= '0;
      end
      if (state_r == ST_RUN) begin
        run_r <= run_r + RUN_W'(1);
        if (capture && (acc[DIGIT_BITS-1:0] != '0)) begin
          nlast_r <= NCNT_W'(col_off) + NCNT_W'(1);
        end
        if (run_end) begin
          a_len_r <= '0;
          b_len_r <= '0;
        end
      end
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
        emit_r      <= emit_r + PIDX_W'(1);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_product_digit    = out_digit_r;
  assign out_last_digit       = out_last_r;
  assign out_negative         = out_neg_r;
  assign out_operand_overflow = out_ovf_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    a_len_r <= LEN_W'(MAX_DIGITS) && b_len_r <= LEN_W'(MAX_DIGITS))
    else $error("operand length past capacity");

  start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall && (state_r == ST_RUN))
    else $error("multiply did not enter the row");

  trim_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nlast_r <= NCNT_W'(PROD_DEPTH))
    else $error("product count past store depth");

  emit_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && (state_nxt == ST_IDLE) |=> out_valid && out_last_digit)
    else $error("emission ended without a last word");

  zero_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && out_free && zero_prod |=> !out_negative && out_last_digit)
    else $error("zero product word malformed");

endmodule
`default_nettype wire
